>>> sv/idbw_pkg.sv
// idbw_pkg: shared types and constants of the i2c display byte writer
// frame layout, control byte codes, register map and the pin write struct
// no dependencies
package idbw_pkg;

    localparam int unsigned STEP_W       = 7;
    localparam int unsigned FRAME_WRITES = 85;
    localparam int unsigned START_WRITES = 4;
    localparam int unsigned BYTE_WRITES  = 26;
    localparam int unsigned BIT_WRITES   = 24;
    localparam int unsigned STOP_FIRST   = START_WRITES + 3 * BYTE_WRITES;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAME_WRITES - 1);

    localparam logic [7:0] CTRL_CMD     = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;
    localparam logic [7:0] DEV_ADDR_RST = 8'h78;

    localparam int unsigned PADDR_W = 3;
    localparam logic        REG_DEV_ADDR = 1'b0;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // one pin write: at most one of the two pins changes per step
    typedef struct packed {
        logic scl_we;
        logic scl_val;
        logic sda_we;
        logic sda_val;
    } t_pin_wr;

endpackage

>>> sv/idbw_in_if.sv
// idbw_in_if: request channel of the i2c display byte writer
// valid/ready handshake carrying op, is_data and value
// no dependencies
interface idbw_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic       is_data;
    logic [7:0] value;

    modport source (output valid, output op, output is_data, output value, input ready);
    modport sink   (input valid, input op, input is_data, input value, output ready);
endinterface

>>> sv/idbw_out_if.sv
// idbw_out_if: result channel of the i2c display byte writer
// valid/ready handshake carrying pin levels and status flags
// no dependencies
interface idbw_out_if;
    logic valid;
    logic ready;
    logic scl;
    logic sda;
    logic busy_res;
    logic accepted;
    logic frame_end;

    modport source (output valid, output scl, output sda, output busy_res,
                    output accepted, output frame_end, input ready);
    modport sink   (input valid, input scl, input sda, input busy_res,
                    input accepted, input frame_end, output ready);
endinterface

>>> sv/idbw_apb_regs.sv
// idbw_apb_regs: apb-style configuration port holding the device address
// depends on idbw_pkg
module idbw_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [idbw_pkg::PADDR_W-1:0] i_paddr,
    input  logic [31:0]                  i_pwdata,
    output logic [31:0]                  o_prdata,
    output logic                         o_pready,
    output logic [7:0]                   o_dev_addr
);
    logic [7:0] r_addr_val;
    logic [7:0] n_addr_val;
    logic       w_sel_addr;

    assign w_sel_addr = (i_paddr[2] == idbw_pkg::REG_DEV_ADDR);

    always_comb begin
        n_addr_val = r_addr_val;
        if (i_psel && i_penable && i_pwrite && w_sel_addr) begin
            n_addr_val = i_pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_val <= idbw_pkg::DEV_ADDR_RST;
        end else begin
            r_addr_val <= n_addr_val;
        end
    end

    assign o_prdata   = w_sel_addr ? {24'd0, r_addr_val} : 32'd0;
    assign o_pready   = 1'b1;
    assign o_dev_addr = r_addr_val;
endmodule

>>> sv/idbw_step_dec.sv
// idbw_step_dec: decodes a frame step number into the pin write it applies
// start, three bytes msb first, each with an unsampled acknowledge clock, then stop
// depends on idbw_pkg
module idbw_step_dec (
    input  logic [idbw_pkg::STEP_W-1:0] i_step,
    input  logic [7:0]                  i_dev_addr,
    input  logic                        i_data_flag,
    input  logic [7:0]                  i_payload,
    output idbw_pkg::t_pin_wr           o_wr
);
    logic [idbw_pkg::STEP_W-1:0] w_t;
    logic [4:0]                  w_r;
    logic [1:0]                  w_which;
    logic [8:0]                  w_prod;
    logic [2:0]                  w_bit;
    logic [4:0]                  w_three_bit;
    logic [1:0]                  w_phase;
    logic [7:0]                  w_byte;
    logic [idbw_pkg::STEP_W-1:0] w_k;

    always_comb begin
        w_t = i_step - idbw_pkg::STEP_W'(idbw_pkg::START_WRITES);
        if (w_t < idbw_pkg::STEP_W'(idbw_pkg::BYTE_WRITES)) begin
            w_which = 2'd0;
            w_r     = w_t[4:0];
        end else if (w_t < idbw_pkg::STEP_W'(2 * idbw_pkg::BYTE_WRITES)) begin
            w_which = 2'd1;
            w_r     = 5'(w_t - idbw_pkg::STEP_W'(idbw_pkg::BYTE_WRITES));
        end else begin
            w_which = 2'd2;
            w_r     = 5'(w_t - idbw_pkg::STEP_W'(2 * idbw_pkg::BYTE_WRITES));
        end
        // r / 3 for r below 24 as (r * 11) >> 5
        w_prod      = {4'd0, w_r} * 9'd11;
        w_bit       = w_prod[7:5];
        w_three_bit = {2'd0, w_bit} + {1'b0, w_bit, 1'b0};
        w_phase     = 2'(w_r - w_three_bit);
        case (w_which)
            2'd0:    w_byte = i_dev_addr;
            2'd1:    w_byte = i_data_flag ? idbw_pkg::CTRL_DATA : idbw_pkg::CTRL_CMD;
            default: w_byte = i_payload;
        endcase
        w_k = i_step - idbw_pkg::STEP_W'(idbw_pkg::STOP_FIRST);

        o_wr = '0;
        if (i_step < idbw_pkg::STEP_W'(idbw_pkg::START_WRITES)) begin
            case (i_step[1:0])
                2'd0:    begin o_wr.sda_we = 1'b1; o_wr.sda_val = 1'b1; end
                2'd1:    begin o_wr.scl_we = 1'b1; o_wr.scl_val = 1'b1; end
                2'd2:    begin o_wr.sda_we = 1'b1; o_wr.sda_val = 1'b0; end
                default: begin o_wr.scl_we = 1'b1; o_wr.scl_val = 1'b0; end
            endcase
        end else if (i_step < idbw_pkg::STEP_W'(idbw_pkg::STOP_FIRST)) begin
            if (w_r < 5'(idbw_pkg::BIT_WRITES)) begin
                case (w_phase)
                    2'd0: begin
                        o_wr.sda_we  = 1'b1;
                        o_wr.sda_val = w_byte[~w_bit];
                    end
                    2'd1:    begin o_wr.scl_we = 1'b1; o_wr.scl_val = 1'b1; end
                    default: begin o_wr.scl_we = 1'b1; o_wr.scl_val = 1'b0; end
                endcase
            end else begin
                // acknowledge clock, acknowledge not sampled
                o_wr.scl_we  = 1'b1;
                o_wr.scl_val = (w_r == 5'(idbw_pkg::BIT_WRITES));
            end
        end else begin
            case (w_k[1:0])
                2'd0:    begin o_wr.sda_we = 1'b1; o_wr.sda_val = 1'b0; end
                2'd1:    begin o_wr.scl_we = 1'b1; o_wr.scl_val = 1'b1; end
                default: begin o_wr.sda_we = 1'b1; o_wr.sda_val = 1'b1; end
            endcase
        end
    end
endmodule

>>> sv/i2c_display_byte_writer.sv
// i2c_display_byte_writer: top level of the bit-banged i2c display byte writer
// frame state, pin levels and the result register
// depends on idbw_pkg, idbw_in_if, idbw_out_if, idbw_apb_regs, idbw_step_dec
//
// Usage: each request on i_in is either a transfer request (op 0, with is_data
// and value) or one tick of time (op 1). An accepted transfer request starts an
// 85-write frame: start, device address, control byte (0x40 data, 0x00 command),
// payload, stop; every later tick applies one pin write. A transfer request
// while a frame is in progress is refused and reported with accepted = 0.
// Every request gives exactly one result on o_out with the pin levels after it,
// busy_res, accepted and frame_end (set on the tick that applied the stop).
// The result is registered and becomes valid in the cycle after acceptance;
// one request is taken per cycle unless a result waits untaken on o_out.
// The result register frees the input side: i_in stays ready
// while o_out is empty or its result is taken in the same cycle, and stalls
// only while a result waits. The device address sits on the APB port at
// address 0 and is read live. After reset the pins are high, no frame is
// active, no result is pending and the device address is 0x78.
module i2c_display_byte_writer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    idbw_in_if.sink                      i_in,
    idbw_out_if.source                   o_out,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [idbw_pkg::PADDR_W-1:0] i_paddr,
    input  logic [31:0]                  i_pwdata,
    output logic [31:0]                  o_prdata,
    output logic                         o_pready
);
    logic [7:0]                  w_dev_addr;
    logic                        w_take;
    logic [idbw_pkg::STEP_W-1:0] w_step_sat;
    idbw_pkg::t_pin_wr           w_wr;

    logic                        r_scl, n_scl;
    logic                        r_sda, n_sda;
    logic [idbw_pkg::STEP_W-1:0] r_step, n_step;
    logic                        r_sending, n_sending;
    logic                        r_data_flag, n_data_flag;
    logic [7:0]                  r_payload, n_payload;
    logic                        r_out_valid, n_out_valid;
    logic                        r_res_acc, n_res_acc;
    logic                        r_res_end, n_res_end;

    idbw_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready),
        .o_dev_addr (w_dev_addr)
    );

    assign w_step_sat = (r_step > idbw_pkg::LAST_STEP) ? idbw_pkg::LAST_STEP : r_step;

    idbw_step_dec u_dec (
        .i_step      (w_step_sat),
        .i_dev_addr  (w_dev_addr),
        .i_data_flag (r_data_flag),
        .i_payload   (r_payload),
        .o_wr        (w_wr)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_step      = r_step;
        n_sending   = r_sending;
        n_data_flag = r_data_flag;
        n_payload   = r_payload;
        n_res_acc   = r_res_acc;
        n_res_end   = r_res_end;
        n_out_valid = r_out_valid && !o_out.ready;
        if (w_take) begin
            n_out_valid = 1'b1;
            n_res_acc   = 1'b0;
            n_res_end   = 1'b0;
            if (i_in.op == idbw_pkg::OP_REQUEST) begin
                if (!r_sending) begin
                    n_data_flag = i_in.is_data;
                    n_payload   = i_in.value;
                    n_step      = '0;
                    n_sending   = 1'b1;
                    n_res_acc   = 1'b1;
                end
            end else if (r_sending) begin
                if (w_wr.scl_we) begin
                    n_scl = w_wr.scl_val;
                end
                if (w_wr.sda_we) begin
                    n_sda = w_wr.sda_val;
                end
                if (w_step_sat == idbw_pkg::LAST_STEP) begin
                    n_sending = 1'b0;
                    n_step    = '0;
                    n_res_end = 1'b1;
                end else begin
                    n_step = w_step_sat + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_step      <= '0;
            r_sending   <= 1'b0;
            r_data_flag <= 1'b0;
            r_payload   <= 8'd0;
            r_out_valid <= 1'b0;
            r_res_acc   <= 1'b0;
            r_res_end   <= 1'b0;
        end else begin
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_step      <= n_step;
            r_sending   <= n_sending;
            r_data_flag <= n_data_flag;
            r_payload   <= n_payload;
            r_out_valid <= n_out_valid;
            r_res_acc   <= n_res_acc;
            r_res_end   <= n_res_end;
        end
    end

    // pins and busy live in the frame state, which only moves on a taken request
    assign o_out.valid     = r_out_valid;
    assign o_out.scl       = r_scl;
    assign o_out.sda       = r_sda;
    assign o_out.busy_res  = r_sending;
    assign o_out.accepted  = r_res_acc;
    assign o_out.frame_end = r_res_end;
endmodule
